>>> hw/rtl/assert_macros.svh
// assertion helpers used by the jitter buffer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/sqjb_pkg.sv
package sqjb_pkg;

    localparam int SEQ_W = 16;

    // request opcodes
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_PUSH = 2'd1;
    localparam logic [1:0] OP_PULL = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_BYTE   = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;

    // push status codes
    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_EVICT    = 3'd1;
    localparam logic [2:0] STS_TOO_LONG = 3'd2;
    localparam logic [2:0] STS_STALE    = 3'd3;
    localparam logic [2:0] STS_DUP      = 3'd4;
    localparam logic [2:0] STS_OLDER    = 3'd5;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_COMPARE,
        CELL_DROP,
        CELL_INSERT
    } t_cell_op;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic             vad;
    } t_slot;

    typedef struct packed {
        t_cell_op op;
        t_slot    key;
    } t_cell_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_DECIDE,
        ST_COPY,
        ST_PULL,
        ST_EMIT
    } t_state;

    // a newer than b under 16-bit wraparound
    function automatic logic seq_after(input logic [SEQ_W-1:0] a,
                                       input logic [SEQ_W-1:0] b);
        logic [SEQ_W-1:0] d;
        d = a - b;
        return (d != '0) && !d[SEQ_W-1];
    endfunction

endpackage

>>> hw/rtl/sqjb_if.sv
interface sqjb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [4:0]  byte_index;
    logic [7:0]  byte_value;
    logic [15:0] seq;
    logic        vad_in;
    logic [7:0]  frame_length;

    modport source (
        output valid, opcode, byte_index, byte_value, seq, vad_in, frame_length,
        input  ready
    );
    modport sink (
        input  valid, opcode, byte_index, byte_value, seq, vad_in, frame_length,
        output ready
    );
endinterface

interface sqjb_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [7:0]  byte_out;
    logic [4:0]  byte_position;
    logic        last;
    logic        vad_out;
    logic [15:0] seq_out;
    logic [5:0]  length_out;

    modport source (
        output valid, kind, status, byte_out, byte_position, last, vad_out,
               seq_out, length_out,
        input  ready
    );
    modport sink (
        input  valid, kind, status, byte_out, byte_position, last, vad_out,
               seq_out, length_out,
        output ready
    );
endinterface

>>> hw/rtl/sqjb_cell.sv
module sqjb_cell import sqjb_pkg::*; #(
    parameter int IDX_W    = 4,
    parameter int PTR_W    = 3,
    parameter int CELL_IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_cmd        i_cmd,
    input  logic [IDX_W-1:0] i_fill,
    input  logic [IDX_W-1:0] i_pos,
    input  logic [PTR_W-1:0] i_ptr_bcast,
    input  t_slot            i_lo_slot,
    input  logic [PTR_W-1:0] i_lo_ptr,
    input  t_slot            i_hi_slot,
    input  logic [PTR_W-1:0] i_hi_ptr,
    output t_slot            o_slot,
    output logic [PTR_W-1:0] o_ptr,
    output logic             o_match,
    output logic             o_newer
);

    localparam logic [IDX_W-1:0] MY_IDX    = IDX_W'(CELL_IDX);
    localparam logic [IDX_W-1:0] MY_IDX_P1 = IDX_W'(CELL_IDX + 1);

    t_slot            r_slot, n_slot;
    logic [PTR_W-1:0] r_ptr, n_ptr;
    logic             r_match, n_match;
    logic             r_newer, n_newer;
    logic             s_occ;

    assign s_occ = MY_IDX < i_fill;

    always_comb begin
        n_slot  = r_slot;
        n_ptr   = r_ptr;
        n_match = r_match;
        n_newer = r_newer;
        unique case (i_cmd.op)
            CELL_COMPARE: begin
                n_match = s_occ && (r_slot.seq == i_cmd.key.seq);
                n_newer = s_occ && seq_after(r_slot.seq, i_cmd.key.seq);
            end
            CELL_DROP: begin
                // move toward the head, the freed pointer lands behind the last entry
                if (MY_IDX_P1 < i_fill) begin
                    n_slot = i_hi_slot;
                    n_ptr  = i_hi_ptr;
                end else if (MY_IDX_P1 == i_fill) begin
                    n_ptr = i_ptr_bcast;
                end
            end
            CELL_INSERT: begin
                if (MY_IDX == i_pos) begin
                    n_slot = i_cmd.key;
                    n_ptr  = i_ptr_bcast;
                end else if (MY_IDX > i_pos && MY_IDX <= i_fill) begin
                    n_slot = i_lo_slot;
                    n_ptr  = i_lo_ptr;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= PTR_W'(CELL_IDX);
        end else begin
            r_ptr <= n_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot  <= n_slot;
        r_match <= n_match;
        r_newer <= n_newer;
    end

    assign o_slot  = r_slot;
    assign o_ptr   = r_ptr;
    assign o_match = r_match;
    assign o_newer = r_newer;

endmodule

>>> hw/rtl/sequence_sorted_jitter_buffer.sv
// Jitter buffer holding up to SLOTS audio frames of FRAME_BYTES bytes, kept in
// ascending sequence order by a chain of slot cells; each cell holds one
// sequence number, voice flag and a pointer into the frame memory, and
// inserts and removals move entries one cell along the chain. One request
// is handled at a time. After its accepting cycle a push compares and
// decides (twice when the oldest frame is evicted), then copies the staged
// bytes into the frame memory through its single write port (skipped when
// the push is refused), then posts the status; a pull streams the oldest
// frame at one byte per cycle from the single read port while the output is
// not stalled; an empty pull posts an empty result. Output stalls hold the
// status and byte steps. There is no clearing pass after reset; frames are
// read only from slots that have been written in full.
`include "assert_macros.svh"

module sequence_sorted_jitter_buffer import sqjb_pkg::*; #(
    parameter int FRAME_BYTES = 32,
    parameter int SLOTS       = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sqjb_in_if.sink       i_in,
    sqjb_out_if.source    o_out
);

    localparam int PTR_W = $clog2(SLOTS);
    localparam int IDX_W = $clog2(SLOTS + 1);
    localparam int BW    = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam int STG   = 32;

    // control state
    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_fill, n_fill;
    logic [15:0]      r_last_pulled, n_last_pulled;
    logic             r_pulled_once, n_pulled_once;
    logic             r_evicted, n_evicted;
    logic [BW-1:0]    r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;

    // request payload and result fields
    t_slot            r_key, n_key;
    logic [7:0]       r_key_len, n_key_len;
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [2:0]       r_status, n_status;
    logic [1:0]       r_emit_kind, n_emit_kind;
    logic [1:0]       r_out_kind, n_out_kind;
    logic [2:0]       r_out_status, n_out_status;
    logic [4:0]       r_out_pos, n_out_pos;
    logic             r_out_last, n_out_last;
    logic             r_out_vad, n_out_vad;
    logic [15:0]      r_out_seq, n_out_seq;
    logic [5:0]       r_out_len, n_out_len;

    // staging buffer and frame memory
    logic [7:0]       r_staging [STG];
    logic [7:0]       r_mem [SLOTS][FRAME_BYTES];
    logic [7:0]       r_rd_byte;

    // cell chain
    t_cell_cmd        s_cmd;
    logic [IDX_W-1:0] s_pos;
    logic [PTR_W-1:0] s_bcast;
    t_slot            s_cell_slot [SLOTS];
    logic [PTR_W-1:0] s_cell_ptr  [SLOTS];
    logic [SLOTS-1:0] s_match;
    logic [SLOTS-1:0] s_newer;

    logic             s_accept;
    logic             s_adv;
    logic             s_cnt_last;
    logic             s_rd_en;
    logic             s_wr_en;
    logic [7:0]       s_cnt8;
    logic [7:0]       s_stage_byte;
    logic             s_too_long;
    logic             s_stale;
    logic             s_dup;
    logic             s_full;
    logic             s_head_newer;
    logic [IDX_W-1:0] s_ins_pos;
    logic [PTR_W-1:0] s_free_ptr;
    logic [SLOTS-1:0] s_ptr_mask;

    assign i_in.ready = (r_state == ST_IDLE);
    assign s_accept   = i_in.valid && i_in.ready;
    // output register is free or being emptied this cycle
    assign s_adv      = !r_out_valid || o_out.ready;
    assign s_cnt_last = (r_cnt == BW'(FRAME_BYTES - 1));

    // ------------------------------------------------------------------
    // slot cells, each handing entries to its neighbors
    // ------------------------------------------------------------------
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        t_slot            lo_slot, hi_slot;
        logic [PTR_W-1:0] lo_ptr, hi_ptr;

        if (g == 0) begin : g_first
            assign lo_slot = '0;
            assign lo_ptr  = '0;
        end else begin : g_mid_lo
            assign lo_slot = s_cell_slot[g-1];
            assign lo_ptr  = s_cell_ptr[g-1];
        end

        if (g == SLOTS - 1) begin : g_last
            assign hi_slot = s_cell_slot[g];
            assign hi_ptr  = s_cell_ptr[g];
        end else begin : g_mid_hi
            assign hi_slot = s_cell_slot[g+1];
            assign hi_ptr  = s_cell_ptr[g+1];
        end

        sqjb_cell #(
            .IDX_W    (IDX_W),
            .PTR_W    (PTR_W),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (s_cmd),
            .i_fill      (r_fill),
            .i_pos       (s_pos),
            .i_ptr_bcast (s_bcast),
            .i_lo_slot   (lo_slot),
            .i_lo_ptr    (lo_ptr),
            .i_hi_slot   (hi_slot),
            .i_hi_ptr    (hi_ptr),
            .o_slot      (s_cell_slot[g]),
            .o_ptr       (s_cell_ptr[g]),
            .o_match     (s_match[g]),
            .o_newer     (s_newer[g])
        );
    end

    // ------------------------------------------------------------------
    // push checks, all from registered request fields and cell state
    // ------------------------------------------------------------------
    assign s_too_long   = r_key_len > 8'(FRAME_BYTES);
    assign s_stale      = r_pulled_once && !seq_after(r_key.seq, r_last_pulled);
    assign s_dup        = |s_match;
    assign s_full       = (r_fill == IDX_W'(SLOTS));
    assign s_head_newer = seq_after(r_key.seq, s_cell_slot[0].seq);

    // first held entry newer than the key, else the tail
    always_comb begin
        s_ins_pos = r_fill;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (s_newer[i]) begin
                s_ins_pos = IDX_W'(i);
            end
        end
    end

    // pointer sitting just past the last held entry is free
    always_comb begin
        s_free_ptr = s_cell_ptr[0];
        for (int i = 0; i < SLOTS; i++) begin
            if (r_fill == IDX_W'(i)) begin
                s_free_ptr = s_cell_ptr[i];
            end
        end
    end

    // staged byte for the copy, zero past the frame length
    assign s_cnt8       = 8'(r_cnt);
    assign s_stage_byte = (s_cnt8 < r_key_len && s_cnt8 < 8'(STG))
                        ? r_staging[s_cnt8[4:0]] : 8'd0;

    assign s_wr_en = (r_state == ST_COPY);
    assign s_rd_en = (r_state == ST_PULL) && s_adv;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state       = r_state;
        n_fill        = r_fill;
        n_last_pulled = r_last_pulled;
        n_pulled_once = r_pulled_once;
        n_evicted     = r_evicted;
        n_cnt         = r_cnt;
        n_key         = r_key;
        n_key_len     = r_key_len;
        n_wr_ptr      = r_wr_ptr;
        n_status      = r_status;
        n_emit_kind   = r_emit_kind;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_out_kind    = r_out_kind;
        n_out_status  = r_out_status;
        n_out_pos     = r_out_pos;
        n_out_last    = r_out_last;
        n_out_vad     = r_out_vad;
        n_out_seq     = r_out_seq;
        n_out_len     = r_out_len;
        s_cmd.op      = CELL_HOLD;
        s_cmd.key     = r_key;
        s_pos         = s_ins_pos;
        s_bcast       = s_cell_ptr[0];

        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    unique case (i_in.opcode)
                        OP_PUSH: begin
                            n_key.seq = i_in.seq;
                            n_key.vad = i_in.vad_in;
                            n_key_len = i_in.frame_length;
                            n_evicted = 1'b0;
                            n_state   = ST_CMP;
                        end
                        OP_PULL: begin
                            n_cnt = '0;
                            if (r_fill == '0) begin
                                n_status    = STS_OK;
                                n_emit_kind = KIND_EMPTY;
                                n_state     = ST_EMIT;
                            end else begin
                                n_state = ST_PULL;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_CMP: begin
                s_cmd.op = CELL_COMPARE;
                n_state  = ST_DECIDE;
            end
            ST_DECIDE: begin
                n_emit_kind = KIND_STATUS;
                if (s_too_long) begin
                    n_status = STS_TOO_LONG;
                    n_state  = ST_EMIT;
                end else if (s_stale) begin
                    n_status = STS_STALE;
                    n_state  = ST_EMIT;
                end else if (s_dup) begin
                    n_status = STS_DUP;
                    n_state  = ST_EMIT;
                end else if (s_full && !s_head_newer) begin
                    n_status = STS_OLDER;
                    n_state  = ST_EMIT;
                end else if (s_full) begin
                    // evict the oldest, then compare again on the shorter chain
                    s_cmd.op  = CELL_DROP;
                    s_bcast   = s_cell_ptr[0];
                    n_fill    = r_fill - 1'b1;
                    n_evicted = 1'b1;
                    n_state   = ST_CMP;
                end else begin
                    s_cmd.op = CELL_INSERT;
                    s_bcast  = s_free_ptr;
                    n_wr_ptr = s_free_ptr;
                    n_fill   = r_fill + 1'b1;
                    n_cnt    = '0;
                    n_state  = ST_COPY;
                end
            end
            ST_COPY: begin
                n_cnt = r_cnt + 1'b1;
                if (s_cnt_last) begin
                    n_cnt       = '0;
                    n_status    = r_evicted ? STS_EVICT : STS_OK;
                    n_emit_kind = KIND_STATUS;
                    n_state     = ST_EMIT;
                end
            end
            ST_PULL: begin
                if (s_adv) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = KIND_BYTE;
                    n_out_status = STS_OK;
                    n_out_pos    = 5'(r_cnt);
                    n_out_last   = s_cnt_last;
                    n_out_vad    = s_cell_slot[0].vad;
                    n_out_seq    = s_cell_slot[0].seq;
                    n_out_len    = 6'(FRAME_BYTES);
                    n_cnt        = r_cnt + 1'b1;
                    if (s_cnt_last) begin
                        // frame leaves the buffer with its final byte
                        n_cnt         = '0;
                        n_last_pulled = s_cell_slot[0].seq;
                        n_pulled_once = 1'b1;
                        s_cmd.op      = CELL_DROP;
                        s_bcast       = s_cell_ptr[0];
                        n_fill        = r_fill - 1'b1;
                        n_state       = ST_IDLE;
                    end
                end
            end
            ST_EMIT: begin
                if (s_adv) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = r_emit_kind;
                    n_out_status = r_status;
                    n_out_pos    = '0;
                    n_out_last   = 1'b1;
                    n_out_vad    = 1'b0;
                    n_out_seq    = '0;
                    n_out_len    = '0;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_fill        <= '0;
            r_last_pulled <= '0;
            r_pulled_once <= 1'b0;
            r_evicted     <= 1'b0;
            r_cnt         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_fill        <= n_fill;
            r_last_pulled <= n_last_pulled;
            r_pulled_once <= n_pulled_once;
            r_evicted     <= n_evicted;
            r_cnt         <= n_cnt;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key        <= n_key;
        r_key_len    <= n_key_len;
        r_wr_ptr     <= n_wr_ptr;
        r_status     <= n_status;
        r_emit_kind  <= n_emit_kind;
        r_out_kind   <= n_out_kind;
        r_out_status <= n_out_status;
        r_out_pos    <= n_out_pos;
        r_out_last   <= n_out_last;
        r_out_vad    <= n_out_vad;
        r_out_seq    <= n_out_seq;
        r_out_len    <= n_out_len;
    end

    // staging buffer, loads past the frame size are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STG; i++) begin
                r_staging[i] <= 8'd0;
            end
        end else if (s_accept && i_in.opcode == OP_LOAD
                     && 8'(i_in.byte_index) < 8'(FRAME_BYTES)) begin
            r_staging[i_in.byte_index] <= i_in.byte_value;
        end
    end

    // frame memory: one write port for the copy, one registered read port
    always_ff @(posedge i_clk) begin
        if (s_wr_en) begin
            r_mem[r_wr_ptr][r_cnt] <= s_stage_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_rd_en) begin
            r_rd_byte <= r_mem[s_cell_ptr[0]][r_cnt];
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.kind          = r_out_kind;
    assign o_out.status        = r_out_status;
    assign o_out.byte_out      = (r_out_kind == KIND_BYTE) ? r_rd_byte : 8'd0;
    assign o_out.byte_position = r_out_pos;
    assign o_out.last          = r_out_last;
    assign o_out.vad_out       = r_out_vad;
    assign o_out.seq_out       = r_out_seq;
    assign o_out.length_out    = r_out_len;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // cell pointers always form a permutation of the frame slots
    always_comb begin
        s_ptr_mask = '0;
        for (int i = 0; i < SLOTS; i++) begin
            s_ptr_mask = s_ptr_mask | (SLOTS'(1) << s_cell_ptr[i]);
        end
    end

    `ASSERT_SAME(a_ptr_perm, i_clk, i_rst_n, 1'b1, s_ptr_mask == '1, "slot pointers lost")
    `ASSERT_SAME(a_fill_max, i_clk, i_rst_n, 1'b1, r_fill <= IDX_W'(SLOTS), "fill overrun")
    `ASSERT_NEXT(a_pull_drop, i_clk, i_rst_n, r_state == ST_PULL && s_adv && s_cnt_last, r_fill == $past(r_fill) - 1'b1, "pulled frame not removed")

endmodule

>>> verif/sqjb_checker.sv
`timescale 1ns / 100ps

// watches both channels of the jitter buffer, keeps a shadow copy of its
// slots and compares every result with the oldest one still owed
module sqjb_checker import sqjb_pkg::*; #(
    parameter int FRAME_BYTES = 32,
    parameter int SLOTS       = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [4:0]  i_byte_index,
    input  logic [7:0]  i_byte_value,
    input  logic [15:0] i_seq,
    input  logic        i_vad_in,
    input  logic [7:0]  i_frame_length,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_kind,
    input  logic [2:0]  i_status,
    input  logic [7:0]  i_byte_out,
    input  logic [4:0]  i_byte_position,
    input  logic        i_last,
    input  logic        i_vad_out,
    input  logic [15:0] i_seq_out,
    input  logic [5:0]  i_length_out,
    output logic [31:0] o_pending,
    output logic [31:0] o_errors
);

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  status;
        logic [7:0]  byte_out;
        logic [4:0]  byte_position;
        logic        last;
        logic        vad_out;
        logic [15:0] seq_out;
        logic [5:0]  length_out;
    } t_jb_result;

    t_jb_result owed_results[$];
    t_jb_result oldest_owed;
    int         mismatches = 0;

    // shadow copy of the buffer contents
    logic [7:0]  sh_staging [FRAME_BYTES];
    logic [7:0]  sh_frames  [SLOTS][FRAME_BYTES];
    logic [15:0] sh_seq     [SLOTS];
    logic        sh_vad     [SLOTS];
    int          sh_count;
    logic [15:0] sh_last_pulled;
    logic        sh_pulled_once;

    task automatic report(input string what);
        $display("%0t: mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] wanted);
        if (got !== wanted)
            report($sformatf("%s is %0h, wanted %0h", name, got, wanted));
    endtask

    // a newer than b under 16-bit wraparound
    function automatic logic is_newer(input logic [15:0] a, input logic [15:0] b);
        logic [15:0] d;
        d = a - b;
        return (d != 16'd0) && (d < 16'h8000);
    endfunction

    function automatic void shadow_drop_oldest();
        int i;
        int b;
        for (i = 0; i < sh_count - 1; i++) begin
            for (b = 0; b < FRAME_BYTES; b++)
                sh_frames[i][b] = sh_frames[i + 1][b];
            sh_seq[i] = sh_seq[i + 1];
            sh_vad[i] = sh_vad[i + 1];
        end
        if (sh_count > 0)
            sh_count--;
    endfunction

    function automatic logic [2:0] shadow_push(input logic [15:0] sq, input logic vad,
                                               input logic [7:0] len);
        int          i;
        int          b;
        int          pos;
        logic [2:0]  sts;
        sts = STS_OK;
        if (int'(len) > FRAME_BYTES)
            return STS_TOO_LONG;
        if (sh_pulled_once && !is_newer(sq, sh_last_pulled))
            return STS_STALE;
        for (i = 0; i < sh_count; i++)
            if (sh_seq[i] == sq)
                return STS_DUP;
        if (sh_count >= SLOTS) begin
            if (!is_newer(sq, sh_seq[0]))
                return STS_OLDER;
            shadow_drop_oldest();
            sts = STS_EVICT;
        end
        // first held slot newer than the new frame
        pos = sh_count;
        for (i = sh_count - 1; i >= 0; i--)
            if (is_newer(sh_seq[i], sq))
                pos = i;
        for (i = sh_count; i > pos; i--) begin
            for (b = 0; b < FRAME_BYTES; b++)
                sh_frames[i][b] = sh_frames[i - 1][b];
            sh_seq[i] = sh_seq[i - 1];
            sh_vad[i] = sh_vad[i - 1];
        end
        for (b = 0; b < FRAME_BYTES; b++)
            sh_frames[pos][b] = (b < int'(len)) ? sh_staging[b] : 8'h00;
        sh_seq[pos] = sq;
        sh_vad[pos] = vad;
        sh_count++;
        return sts;
    endfunction

    task automatic shadow_request(input logic [1:0] op, input logic [4:0] idx,
                                  input logic [7:0] val, input logic [15:0] sq,
                                  input logic vad, input logic [7:0] len);
        t_jb_result r;
        int         b;
        r = '0;
        case (op)
            OP_LOAD: begin
                if (int'(idx) < FRAME_BYTES)
                    sh_staging[idx] = val;
            end
            OP_PUSH: begin
                r.kind   = KIND_STATUS;
                r.status = shadow_push(sq, vad, len);
                r.last   = 1'b1;
                owed_results.push_back(r);
            end
            OP_PULL: begin
                if (sh_count == 0) begin
                    r.kind = KIND_EMPTY;
                    r.last = 1'b1;
                    owed_results.push_back(r);
                end else begin
                    for (b = 0; b < FRAME_BYTES; b++) begin
                        r.kind          = KIND_BYTE;
                        r.byte_out      = sh_frames[0][b];
                        r.byte_position = 5'(b);
                        r.last          = (b == FRAME_BYTES - 1);
                        r.vad_out       = sh_vad[0];
                        r.seq_out       = sh_seq[0];
                        r.length_out    = 6'(FRAME_BYTES);
                        owed_results.push_back(r);
                    end
                    sh_last_pulled = sh_seq[0];
                    sh_pulled_once = 1'b1;
                    shadow_drop_oldest();
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < FRAME_BYTES; b++)
                sh_staging[b] = 8'h00;
            sh_count       = 0;
            sh_last_pulled = 16'h0000;
            sh_pulled_once = 1'b0;
            owed_results.delete();
        end else begin
            // results first, a request can't answer itself in the same cycle
            if (i_out_valid && i_out_ready) begin
                if (owed_results.size() == 0) begin
                    report("result arrived with nothing owed");
                end else begin
                    oldest_owed = owed_results.pop_front();
                    check_field("kind", 16'(i_kind), 16'(oldest_owed.kind));
                    check_field("status", 16'(i_status), 16'(oldest_owed.status));
                    check_field("byte_out", 16'(i_byte_out), 16'(oldest_owed.byte_out));
                    check_field("byte_position", 16'(i_byte_position),
                                16'(oldest_owed.byte_position));
                    check_field("last", 16'(i_last), 16'(oldest_owed.last));
                    check_field("vad_out", 16'(i_vad_out), 16'(oldest_owed.vad_out));
                    check_field("seq_out", i_seq_out, oldest_owed.seq_out);
                    check_field("length_out", 16'(i_length_out),
                                16'(oldest_owed.length_out));
                end
            end
            if (i_in_valid && i_in_ready)
                shadow_request(i_opcode, i_byte_index, i_byte_value, i_seq, i_vad_in,
                               i_frame_length);
        end
        o_pending <= 32'(owed_results.size());
        o_errors  <= 32'(mismatches);
    end

endmodule

>>> verif/tb_sequence_sorted_jitter_buffer.sv
`timescale 1ns / 100ps

module tb_sequence_sorted_jitter_buffer;
    import sqjb_pkg::*;

    localparam int FRAME_BYTES  = 32;
    localparam int SLOTS        = 8;
    localparam int RANDOM_ITEMS = 450;
    localparam int DRAIN_CYCLES = 100;
    localparam int LONG_HOLD    = 400;
    // the fourth opcode has no meaning, the block must swallow it silently
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic [31:0] pending;
    logic [31:0] errors;

    // gap bookkeeping shared by the sender and receiver processes
    int          tx_quiet     = 0;
    int          rx_quiet     = 0;
    int          hold_request = 0;
    int          push_pct     = 35;
    logic [15:0] stream_seq;

    sqjb_in_if  in_ch ();
    sqjb_out_if out_ch ();

    sequence_sorted_jitter_buffer #(
        .FRAME_BYTES (FRAME_BYTES),
        .SLOTS       (SLOTS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    sqjb_checker #(
        .FRAME_BYTES (FRAME_BYTES),
        .SLOTS       (SLOTS)
    ) i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_ch.valid),
        .i_in_ready      (in_ch.ready),
        .i_opcode        (in_ch.opcode),
        .i_byte_index    (in_ch.byte_index),
        .i_byte_value    (in_ch.byte_value),
        .i_seq           (in_ch.seq),
        .i_vad_in        (in_ch.vad_in),
        .i_frame_length  (in_ch.frame_length),
        .i_out_valid     (out_ch.valid),
        .i_out_ready     (out_ch.ready),
        .i_kind          (out_ch.kind),
        .i_status        (out_ch.status),
        .i_byte_out      (out_ch.byte_out),
        .i_byte_position (out_ch.byte_position),
        .i_last          (out_ch.last),
        .i_vad_out       (out_ch.vad_out),
        .i_seq_out       (out_ch.seq_out),
        .i_length_out    (out_ch.length_out),
        .o_pending       (pending),
        .o_errors        (errors)
    );

    always #5 i_clk = ~i_clk;

    // hard stop well beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    // idle cycles before the next transfer: mostly a random draw, with runs of
    // back-to-back traffic so that no-gap stretches get exercised too
    function automatic int draw_gap(inout int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            quiet_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    // offer one request and return at the edge where it is taken;
    // valid is only dropped when a gap follows, never toggled within a step
    task automatic send_request(input logic [1:0] op, input logic [4:0] idx,
                                input logic [7:0] val, input logic [15:0] sq,
                                input logic vad, input logic [7:0] len);
        int gap;
        gap = draw_gap(tx_quiet);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.opcode       <= op;
        in_ch.byte_index   <= idx;
        in_ch.byte_value   <= val;
        in_ch.seq          <= sq;
        in_ch.vad_in       <= vad;
        in_ch.frame_length <= len;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
    endtask

    // unused fields carry random bits so the block is seen ignoring them
    task automatic load_byte(input logic [4:0] idx, input logic [7:0] val);
        send_request(OP_LOAD, idx, val, 16'($urandom), 1'($urandom), 8'($urandom));
    endtask

    task automatic push_frame(input logic [15:0] sq, input logic vad, input logic [7:0] len);
        send_request(OP_PUSH, 5'($urandom), 8'($urandom), sq, vad, len);
    endtask

    task automatic pull_frame();
        send_request(OP_PULL, 5'($urandom), 8'($urandom), 16'($urandom), 1'($urandom),
                     8'($urandom));
    endtask

    // sender goes quiet until every owed result has been taken
    task automatic wait_all_results();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // one random request, mostly a well-formed audio stream: loads fill the
    // staging area, pushes follow a running sequence number with some
    // reordering, repeats, stale and far-off numbers, pulls drain the oldest
    task automatic random_request(output bit counted);
        int          pick;
        int          sel;
        logic [15:0] sq;
        logic [7:0]  len;
        counted = 1'b1;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            load_byte(5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
        end else if (pick < 40 + push_pct) begin
            sel = $urandom_range(0, 19);
            if (sel < 10) begin
                sq = stream_seq;
                stream_seq = stream_seq + 16'd1;
            end else if (sel < 14) begin
                // late or early arrival, sometimes a repeat
                sq = stream_seq + 16'($urandom_range(0, 5)) - 16'd3;
            end else if (sel < 16) begin
                sq = stream_seq - 16'($urandom_range(1, 12));
            end else if (sel == 16) begin
                // exactly half the sequence space away
                sq = stream_seq + 16'h8000;
            end else if (sel == 17) begin
                sq = 16'($urandom);
            end else if (sel == 18) begin
                // forward jump, walks the stream around the wrap point
                stream_seq = stream_seq + 16'($urandom_range(100, 28672));
                sq = stream_seq;
                stream_seq = stream_seq + 16'd1;
            end else begin
                sq = stream_seq - 16'h7FFF;
            end
            sel = $urandom_range(0, 9);
            if (sel < 5)
                len = 8'(FRAME_BYTES);
            else if (sel < 8)
                len = 8'($urandom_range(0, FRAME_BYTES - 1));
            else
                len = 8'($urandom_range(FRAME_BYTES + 1, 255));
            push_frame(sq, 1'($urandom), len);
        end else if (pick < 98) begin
            pull_frame();
        end else begin
            send_request(OP_UNUSED, 5'($urandom), 8'($urandom), 16'($urandom),
                         1'($urandom), 8'($urandom));
            counted = 1'b0;
        end
    endtask

    // result side: random stalls per result, plus one long hold-off on request
    initial begin : result_drain
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = draw_gap(rx_quiet);
            if (hold_request > 0) begin
                stall        = hold_request;
                hold_request = 0;
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        int sent;
        bit counted;
        in_ch.valid        <= 1'b0;
        in_ch.opcode       <= OP_LOAD;
        in_ch.byte_index   <= '0;
        in_ch.byte_value   <= '0;
        in_ch.seq          <= '0;
        in_ch.vad_in       <= 1'b0;
        in_ch.frame_length <= '0;
        i_rst_n            <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty pull, oversize pushes before anything was pulled
        pull_frame();
        push_frame(16'h1234, 1'b1, 8'(FRAME_BYTES + 1));
        push_frame(16'h1234, 1'b0, 8'hFF);
        // staging extremes, remaining bytes stay at their reset zero
        load_byte(5'd0, 8'hFF);
        load_byte(5'd31, 8'hA5);
        load_byte(5'd5, 8'h00);
        // inserts across the wrap point land out of arrival order
        push_frame(16'hFFFE, 1'b1, 8'(FRAME_BYTES));
        push_frame(16'hFFFF, 1'b0, 8'd0);
        push_frame(16'h0001, 1'b1, 8'd5);
        push_frame(16'h0000, 1'b0, 8'd1);
        // repeat of a held number
        push_frame(16'hFFFF, 1'b1, 8'(FRAME_BYTES));
        pull_frame();
        // same as last pulled, then half the sequence space behind it
        push_frame(16'hFFFE, 1'b0, 8'd4);
        push_frame(16'h7FFE, 1'b1, 8'd4);
        // fill every slot
        for (int s = 2; s <= 6; s++)
            push_frame(16'(s), 1'(s), 8'(FRAME_BYTES - s));
        // full: newer one evicts the oldest, older one is refused
        push_frame(16'h0010, 1'b1, 8'(FRAME_BYTES - 1));
        push_frame(16'hFFFF, 1'b0, 8'(FRAME_BYTES));
        send_request(OP_UNUSED, 5'h1F, 8'hFF, 16'hFFFF, 1'b1, 8'hFF);
        pull_frame();
        pull_frame();
        wait_all_results();

        stream_seq = 16'h0011;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            // shift the push/pull mix now and then so the buffer both fills
            // up and runs dry
            if (sent % 50 == 0) begin
                case ($urandom_range(0, 2))
                    0:       push_pct = 20;
                    1:       push_pct = 35;
                    default: push_pct = 45;
                endcase
            end
            if (sent == 150) begin
                // long result hold-off while requests keep coming back to back
                hold_request = LONG_HOLD;
                tx_quiet     = 40;
                pull_frame();
                sent++;
            end
            if (sent == 300)
                wait_all_results();
            random_request(counted);
            if (counted)
                sent++;
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
